[src/shfc_pkg.sv]
// shfc_pkg: types, constants and the per-channel sharpen function for the
// 3x3 cross sharpening filter. Depends on nothing; every other file but shfc_ram imports it.
package shfc_pkg;

   // channel and field widths
   localparam int ChanW      = 8;
   localparam int MaxChan    = 3;
   localparam int RowW       = 12;
   localparam int ColOutW    = 10;
   localparam int WidthRegW  = 11;
   localparam int HeightRegW = 13;
   localparam int CsrDataW   = 13;
   localparam int CsrIdxW    = 2;

   // frame limits and register reset values
   localparam int MinDim      = 3;
   localparam int MaxHeight   = 4096;
   localparam int ResetWidth  = 640;
   localparam int ResetHeight = 480;
   localparam int ResetColor  = 1;

   // queue between front and back end
   localparam int QueueDepth = 4;
   localparam int CountW     = $clog2(QueueDepth + 1);

   // kernel centre weight and working width of the signed sum
   localparam int Gain = 5;
   localparam int SumW = 12;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_COLOR_MODE   = 2'd2
   } csr_idx_type;

   // channel k of a pixel sits in element k
   typedef logic [MaxChan-1:0][ChanW-1:0] pix_type;

   // one classified pixel handed from front to back
   typedef struct packed {
      pix_type              up;
      pix_type              centre;
      pix_type              right;
      pix_type              left;
      pix_type              below;
      logic [MaxChan-1:0]   chan_en;
      logic                 border;
      logic                 extra;
      logic [RowW-1:0]      row;
      logic [ColOutW-1:0]   col;
   } job_type;

   // one result word
   typedef struct packed {
      logic [ChanW-1:0]   out_a;
      logic [ChanW-1:0]   out_b;
      logic [ChanW-1:0]   out_c;
      logic [RowW-1:0]    out_row;
      logic [ColOutW-1:0] out_col;
      logic               run_end;
   } rsp_type;

   // 5*centre minus the four neighbours, clipped to 0..255
   function automatic logic [ChanW-1:0] sharpen_chan(
      input logic [ChanW-1:0] centre,
      input logic [ChanW-1:0] left,
      input logic [ChanW-1:0] right,
      input logic [ChanW-1:0] up,
      input logic [ChanW-1:0] below
   );
      logic signed [SumW-1:0] acc;
      logic [ChanW-1:0]       res;
      acc = $signed(SumW'(Gain)) * $signed(SumW'(centre))
            - $signed(SumW'(left)) - $signed(SumW'(right))
            - $signed(SumW'(up)) - $signed(SumW'(below));
      if (acc < 0) begin
         res = '0;
      end else if (acc > $signed(SumW'(255))) begin
         res = '1;
      end else begin
         res = acc[ChanW-1:0];
      end
      return res;
   endfunction

endpackage

[src/shfc_if.sv]
// shfc_if: valid/ready channel interfaces for pixel words, result words and
// register writes. Depends on shfc_pkg for field widths.
interface shfc_req_if;
   import shfc_pkg::*;
   logic             valid;
   logic             ready;
   logic [ChanW-1:0] chan_a;
   logic [ChanW-1:0] chan_b;
   logic [ChanW-1:0] chan_c;
   modport source (output valid, chan_a, chan_b, chan_c, input ready);
   modport sink   (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface shfc_rsp_if;
   import shfc_pkg::*;
   logic               valid;
   logic               ready;
   logic [ChanW-1:0]   out_a;
   logic [ChanW-1:0]   out_b;
   logic [ChanW-1:0]   out_c;
   logic [RowW-1:0]    out_row;
   logic [ColOutW-1:0] out_col;
   logic               run_end;
   modport source (output valid, out_a, out_b, out_c, out_row, out_col, run_end,
                   input ready);
   modport sink   (input valid, out_a, out_b, out_c, out_row, out_col, run_end,
                   output ready);
endinterface

interface shfc_csr_if;
   import shfc_pkg::*;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/shfc_ram.sv]
// shfc_ram: generic single-write, single-read memory with registered read data.
// Depends on nothing.
module shfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[src/shfc_front.sv]
// shfc_front: register port, raster position counters, line buffers and pixel
// classification. Depends on shfc_pkg, shfc_if and shfc_ram.
module shfc_front #(
   parameter int MAX_WIDTH    = 1024,
   parameter int NUM_CHANNELS = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   shfc_req_if.sink                      req,
   shfc_csr_if.sink                      csr,
   input  logic [shfc_pkg::CountW-1:0]   queue_count,
   output logic                          job_push,
   output shfc_pkg::job_type             job
);
   import shfc_pkg::*;

   localparam int NCH    = (NUM_CHANNELS > MaxChan) ? MaxChan : NUM_CHANNELS;
   localparam int PW     = NCH * ChanW;
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int ZW     = (WW > WidthRegW) ? WW : WidthRegW;
   localparam int ResetW = (ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth;

   // registers
   logic [WW-1:0]         width_ff;
   logic [HeightRegW-1:0] height_ff;
   logic                  color_ff;
   logic [CW-1:0]         col_ff;
   logic [RowW-1:0]       row_ff;
   logic                  s1_valid_ff;
   logic                  s1_emit_ff;
   logic                  s1_border_ff;
   logic                  s1_extra_ff;
   logic [RowW-1:0]       s1_row_ff;
   logic [CW-1:0]         s1_col_ff;
   logic [MaxChan-1:0]    s1_chan_en_ff;
   pix_type               s1_pix_ff;
   pix_type               prev_ff;

   // combinational signals
   logic                  accept;
   logic                  csr_write;
   logic [ZW-1:0]         width_req;
   logic [WW-1:0]         width_clamp;
   logic [HeightRegW-1:0] height_req;
   logic [HeightRegW-1:0] height_clamp;
   logic [CountW:0]       used_slots;
   logic                  wrap;
   logic [CW-1:0]         cur_col;
   logic [HeightRegW-1:0] row_step;
   logic [RowW-1:0]       cur_row;
   logic [WW-1:0]         col_inc;
   logic                  col_end;
   logic [HeightRegW-1:0] row_inc;
   logic [RowW-1:0]       row_next;
   logic                  border;
   logic                  last_row;
   logic [MaxChan-1:0]    chan_en;
   pix_type               in_pix;
   pix_type               up;
   pix_type               centre;
   pix_type               right;
   logic [2*PW-1:0]       rdata_a;
   logic [PW-1:0]         rdata_b;

   // register port, always ready
   assign csr.ready = 1'b1;
   assign csr_write = csr.valid && csr.ready;

   // clamp written geometry into its legal range
   always_comb begin
      width_req  = ZW'(csr.data[WidthRegW-1:0]);
      height_req = csr.data[HeightRegW-1:0];
      if (width_req < ZW'(MinDim)) begin
         width_clamp = WW'(MinDim);
      end else if (width_req > ZW'(MAX_WIDTH)) begin
         width_clamp = WW'(MAX_WIDTH);
      end else begin
         width_clamp = WW'(width_req);
      end
      if (height_req < HeightRegW'(MinDim)) begin
         height_clamp = HeightRegW'(MinDim);
      end else if (height_req > HeightRegW'(MaxHeight)) begin
         height_clamp = HeightRegW'(MaxHeight);
      end else begin
         height_clamp = height_req;
      end
   end

   // input handshake: hold back while queue plus stage one could overflow
   assign used_slots = {1'b0, queue_count} + (CountW + 1)'(s1_valid_ff);
   assign req.ready  = !reset && (used_slots < (CountW + 1)'(QueueDepth));
   assign accept     = req.valid && req.ready;

   // position of the pixel being accepted
   always_comb begin
      wrap     = WW'(col_ff) >= width_ff;
      cur_col  = wrap ? '0 : col_ff;
      row_step = wrap ? (HeightRegW'(row_ff) + HeightRegW'(1)) : HeightRegW'(row_ff);
      cur_row  = (row_step >= height_ff) ? '0 : row_step[RowW-1:0];
      col_inc  = WW'(cur_col) + WW'(1);
      col_end  = col_inc >= width_ff;
      row_inc  = HeightRegW'(cur_row) + HeightRegW'(1);
      row_next = (row_inc >= height_ff) ? '0 : row_inc[RowW-1:0];
      border   = (cur_row == RowW'(1)) || (cur_col == '0)
                 || (WW'(cur_col) >= (width_ff - WW'(1)));
      last_row = HeightRegW'(cur_row) == (height_ff - HeightRegW'(1));
   end

   // active channels and the incoming pixel word
   always_comb begin
      in_pix    = '0;
      in_pix[0] = req.chan_a;
      if (NCH > 1) begin
         in_pix[1] = req.chan_b;
      end
      if (NCH > 2) begin
         in_pix[2] = req.chan_c;
      end
      for (int k = 0; k < MaxChan; k++) begin
         chan_en[k] = (k < NCH) && ((k == 0) || color_ff);
      end
   end

   // line buffers: a holds {older, newer} at the column, b holds newer for
   // the right-hand neighbour read
   shfc_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_a (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_col_ff),
      .wdata ({rdata_a[PW-1:0], s1_pix_ff[NCH-1:0]}),
      .raddr (cur_col),
      .rdata (rdata_a)
   );

   shfc_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_b (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_col_ff),
      .wdata (s1_pix_ff[NCH-1:0]),
      .raddr (col_inc[CW-1:0]),
      .rdata (rdata_b)
   );

   // neighbours returned by the line buffers
   always_comb begin
      up                = '0;
      centre            = '0;
      right             = '0;
      up[NCH-1:0]       = rdata_a[2*PW-1:PW];
      centre[NCH-1:0]   = rdata_a[PW-1:0];
      right[NCH-1:0]    = rdata_b;
   end

   // job handed to the queue
   always_comb begin
      job.up      = up;
      job.centre  = centre;
      job.right   = right;
      job.left    = prev_ff;
      job.below   = s1_pix_ff;
      job.chan_en = s1_chan_en_ff;
      job.border  = s1_border_ff;
      job.extra   = s1_extra_ff;
      job.row     = s1_row_ff;
      job.col     = ColOutW'(s1_col_ff);
   end
   assign job_push = s1_valid_ff && s1_emit_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WW'(ResetW);
         height_ff   <= HeightRegW'(ResetHeight);
         color_ff    <= 1'(ResetColor);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         prev_ff     <= '0;
      end else begin
         if (csr_write) begin
            case (csr.index)
               CSR_FRAME_WIDTH:  width_ff  <= width_clamp;
               CSR_FRAME_HEIGHT: height_ff <= height_clamp;
               CSR_COLOR_MODE:   color_ff  <= csr.data[0];
               default: ;
            endcase
         end
         if (accept) begin
            col_ff <= col_end ? '0 : col_inc[CW-1:0];
            row_ff <= col_end ? row_next : cur_row;
         end
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            prev_ff <= centre;
         end
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= in_pix;
         s1_col_ff     <= cur_col;
         s1_row_ff     <= cur_row;
         s1_emit_ff    <= cur_row != '0;
         s1_border_ff  <= border;
         s1_extra_ff   <= last_row;
         s1_chan_en_ff <= chan_en;
      end
   end

`ifndef SYNTH
   // an accepted pixel reaches stage one on the next cycle
   a_stage_one: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel did not reach stage one");

   // credit never lets queue plus stage one exceed the queue depth
   a_credit: assert property (@(posedge clock) disable iff (reset)
      used_slots <= (CountW + 1)'(QueueDepth))
      else $error("queue credit exceeded");
`endif

endmodule

[src/shfc_fifo.sv]
// shfc_fifo: short queue of classified pixels between front and back end.
// Depends on shfc_pkg for the entry type.
module shfc_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  shfc_pkg::job_type            wdata,
   input  logic                         pop,
   output shfc_pkg::job_type            rdata,
   output logic                         not_empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import shfc_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type         mem [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign rdata     = mem[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count     = count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTH
   // a word is never written into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CntW'(DEPTH)))
      else $error("push into full queue");

   // a word is never taken from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");
`endif

endmodule

[src/shfc_back.sv]
// shfc_back: computes the sharpened channels of queued pixels and drives the
// result channel through an output register. Depends on shfc_pkg and shfc_if.
module shfc_back (
   input  logic                clock,
   input  logic                reset,
   input  shfc_pkg::job_type   job,
   input  logic                job_valid,
   output logic                pop,
   shfc_rsp_if.source          rsp
);
   import shfc_pkg::*;

   rsp_type                        out_ff;
   rsp_type                        out_in;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic                           phase_ff;
   logic                           phase_in;
   logic                           load;
   logic [MaxChan-1:0][ChanW-1:0]  vals;

   // output register is free or being emptied this cycle
   assign load = job_valid && (!out_valid_ff || rsp.ready);

   // per-channel kernel, borders and unused channels give zero
   always_comb begin
      for (int k = 0; k < MaxChan; k++) begin
         if (job.border || !job.chan_en[k]) begin
            vals[k] = '0;
         end else begin
            vals[k] = sharpen_chan(job.centre[k], job.left[k], job.right[k],
                                   job.up[k], job.below[k]);
         end
      end
   end

   // sequencing: filtered pixel first, then the zero border on the last row
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in   = 1'b1;
         out_in.out_col = job.col;
         if (!phase_ff) begin
            out_in.out_a   = vals[0];
            out_in.out_b   = vals[1];
            out_in.out_c   = vals[2];
            out_in.out_row = job.row - RowW'(1);
            out_in.run_end = !job.extra;
            if (job.extra) begin
               phase_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            out_in.out_a   = '0;
            out_in.out_b   = '0;
            out_in.out_c   = '0;
            out_in.out_row = job.row;
            out_in.run_end = 1'b1;
            phase_in       = 1'b0;
            pop            = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.out_a   = out_ff.out_a;
   assign rsp.out_b   = out_ff.out_b;
   assign rsp.out_c   = out_ff.out_c;
   assign rsp.out_row = out_ff.out_row;
   assign rsp.out_col = out_ff.out_col;
   assign rsp.run_end = out_ff.run_end;

`ifndef SYNTH
   // a pixel halfway through its two results stays at the queue head
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> job_valid)
      else $error("second result pending with empty queue");

   // the border result on the last row closes its run
   a_second_ends: assert property (@(posedge clock) disable iff (reset)
      (load && phase_ff) |=> (out_valid_ff && out_ff.run_end))
      else $error("second result without run end");
`endif

endmodule

[src/sharpen_filter_3x3_cross_top.sv]
// sharpen_filter_3x3_cross_top: 3x3 cross sharpening filter on a raster pixel
// stream. Depends on shfc_pkg, shfc_if, shfc_front, shfc_fifo and shfc_back.
//
//   channel  dir  word                              handshake
//   req_ch   in   chan_a, chan_b, chan_c            valid/ready
//   rsp_ch   out  out_a/b/c, out_row, out_col,      valid/ready
//                 run_end
//   csr_ch   in   index, data                       valid/ready (always ready)
//
// One pixel is accepted per cycle while input ready is high; its first result
// word passes stage one, the queue and the output register, and covers the
// pixel one row up. On the last row each pixel yields two words, so once the
// four-entry queue fills the input takes one pixel per two result words.
// Line buffers are one write and one read port each; stage one writes the
// column back while the next pixel reads ahead, so no conflict arises.
// Reset clears counters, geometry and queue; line buffers are not cleared.
// Either side may stall freely: input ready drops once queue and stage one
// hold four pixels.
module sharpen_filter_3x3_cross_top #(
   parameter int MAX_WIDTH    = 1024,
   parameter int NUM_CHANNELS = 3
) (
   input  logic          clock,
   input  logic          reset,
   shfc_req_if.sink      req_ch,
   shfc_rsp_if.source    rsp_ch,
   shfc_csr_if.sink      csr_ch
);
   import shfc_pkg::*;

   job_type             push_job;
   job_type             head_job;
   logic                job_push;
   logic                job_pop;
   logic                job_valid;
   logic [CountW-1:0]   queue_count;

   // position tracking, line buffers and classification
   shfc_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .csr         (csr_ch),
      .queue_count (queue_count),
      .job_push    (job_push),
      .job         (push_job)
   );

   // decoupling queue
   shfc_fifo #(
      .DEPTH (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .wdata     (push_job),
      .pop       (job_pop),
      .rdata     (head_job),
      .not_empty (job_valid),
      .count     (queue_count)
   );

   // kernel arithmetic and result sequencing
   shfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_valid (job_valid),
      .pop       (job_pop),
      .rsp       (rsp_ch)
   );

endmodule

[tb/tb_sharpen_filter_3x3_cross_top.sv]
// tb_sharpen_filter_3x3_cross_top: self-checking bench for the 3x3 cross sharpening
// filter; streams pixel words, predicts every result word and compares field by field.
// Depends on shfc_pkg, shfc_if and the RTL under src.
module tb_sharpen_filter_3x3_cross_top;
   timeunit 1ns;
   timeprecision 1ps;

   import shfc_pkg::*;

   localparam int LineDepth   = 1024;
   localparam int CentreGain  = 5;
   localparam int PipeFlush   = 12;
   localparam int LongStall   = 64;
   localparam int IdlePct     = 8;
   localparam int RandomItems = 190;
   localparam int LongRowPart = 24;
   localparam int WatchdogNs  = 400_000;

   logic clock = 1'b0;
   logic reset;

   shfc_req_if req_ch ();
   shfc_rsp_if rsp_ch ();
   shfc_csr_if csr_ch ();

   sharpen_filter_3x3_cross_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow registers and window state of the predictor
   logic [WidthRegW-1:0]  cfg_width  = WidthRegW'(ResetWidth);
   logic [HeightRegW-1:0] cfg_height = HeightRegW'(ResetHeight);
   logic                  cfg_color  = 1'b1;
   pix_type               far_line  [LineDepth];
   pix_type               near_line [LineDepth];
   pix_type               west_px   = '0;
   int unsigned           row_pos   = 0;
   int unsigned           col_pos   = 0;

   rsp_type sharpened_due[$];

   int mismatch_count   = 0;
   int pixels_sent      = 0;
   int words_checked    = 0;
   int settings_applied = 0;
   bit no_idle          = 1'b0;
   bit stall_request    = 1'b0;

   // expected result words for one accepted pixel word
   function automatic void sharpen_predict(input pix_type px);
      int unsigned w, h, r, c;
      int          acc;
      bit          border;
      pix_type     up, mid, rt, sharp;
      rsp_type     word;
      w = cfg_width;
      if (w < MinDim) w = MinDim;
      if (w > LineDepth) w = LineDepth;
      h = cfg_height;
      if (h < MinDim) h = MinDim;
      if (h > MaxHeight) h = MaxHeight;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      up  = far_line[c];
      mid = near_line[c];
      rt  = (c + 1 < LineDepth) ? near_line[c + 1] : '0;
      if (r >= 1) begin
         border = (r == 1) || (c == 0) || (c >= w - 1);
         sharp = '0;
         for (int k = 0; k < MaxChan; k++) begin
            if (!border && (cfg_color || k == 0)) begin
               acc = CentreGain * int'(mid[k]) - int'(west_px[k]) - int'(rt[k])
                     - int'(up[k]) - int'(px[k]);
               if (acc < 0) acc = 0;
               if (acc > 255) acc = 255;
               sharp[k] = 8'(acc);
            end
         end
         word = '0;
         word.out_a   = sharp[0];
         word.out_b   = sharp[1];
         word.out_c   = sharp[2];
         word.out_row = RowW'(r - 1);
         word.out_col = ColOutW'(c);
         // last row also yields its own zero border pixel
         if (r == h - 1) begin
            sharpened_due = {sharpened_due, word};
            word = '0;
            word.out_row = RowW'(r);
            word.out_col = ColOutW'(c);
         end
         word.run_end = 1'b1;
         sharpened_due = {sharpened_due, word};
      end
      far_line[c]  = mid;
      near_line[c] = px;
      west_px      = mid;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [ChanW-1:0] pick_sample();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // result side: random ready, long hold-off on request
   initial begin : rsp_pace
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold = LongStall;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= IdlePct);
         end
      end
   end

   // compare each accepted result word with the oldest one due
   always @(posedge clock) begin : rsp_check
      rsp_type due;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (sharpened_due.size() == 0) begin
            $display("%0t ns: result word with none due, expected nothing, actual row %0d col %0d",
                     $time, rsp_ch.out_row, rsp_ch.out_col);
            mismatch_count++;
         end else begin
            due = sharpened_due.pop_front();
            check_field("out_a",   16'(due.out_a),   16'(rsp_ch.out_a));
            check_field("out_b",   16'(due.out_b),   16'(rsp_ch.out_b));
            check_field("out_c",   16'(due.out_c),   16'(rsp_ch.out_c));
            check_field("out_row", 16'(due.out_row), 16'(rsp_ch.out_row));
            check_field("out_col", 16'(due.out_col), 16'(rsp_ch.out_col));
            check_field("run_end", 16'(due.run_end), 16'(rsp_ch.run_end));
            words_checked++;
         end
      end
   end

   // one pixel word; entered and left at a falling edge, valid stays up
   task automatic send_pixel(input logic [ChanW-1:0] a, b, c);
      if (!no_idle) begin
         while ($urandom_range(99) < IdlePct) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid  <= 1'b1;
      req_ch.chan_a <= a;
      req_ch.chan_b <= b;
      req_ch.chan_c <= c;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sharpen_predict({c, b, a});
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_pixel();
      send_pixel(pick_sample(), pick_sample(), pick_sample());
   endtask

   // stop sending and wait until the block is idle
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (sharpened_due.size() != 0) @(negedge clock);
      repeat (PipeFlush) @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CsrDataW-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = value[WidthRegW-1:0];
         CSR_FRAME_HEIGHT: cfg_height = value[HeightRegW-1:0];
         CSR_COLOR_MODE:   cfg_color  = value[0];
         default:          ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_geometry(input logic [CsrDataW-1:0] w, h, input logic color);
      quiesce();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_COLOR_MODE, CsrDataW'(color));
      csr_ch.valid <= 1'b0;
      settings_applied++;
   endtask

   // send random pixels until the next word starts a frame
   task automatic finish_frame();
      while (!(row_pos == 0 && col_pos == 0)) send_random_pixel();
   endtask

   // silent first row at reset geometry, then width and height cut mid-frame in grey
   task automatic test_start_and_regrid();
      send_pixel(8'h00, 8'hFF, 8'hFF);
      send_pixel(8'd20, 8'd1, 8'd2);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'd7, 8'd7, 8'd7);
      send_pixel(8'd128, 8'd128, 8'd128);
      apply_geometry(13'd3, 13'd480, 1'b0);
      send_pixel(8'd30, 8'd9, 8'd9);
      send_pixel(8'd100, 8'd200, 8'd50);
      send_pixel(8'd40, 8'hFF, 8'h00);
      apply_geometry(13'd3, 13'd3, 1'b0);
      send_pixel(8'd50, 8'hFF, 8'hFF);
      send_pixel(8'd60, 8'd1, 8'd1);
      send_pixel(8'd70, 8'h00, 8'h00);
   endtask

   // checkerboard drives channels a and b to both clip limits, c stays in range
   task automatic test_saturation();
      bit on;
      apply_geometry(13'd4, 13'd3, 1'b1);
      for (int rr = 0; rr < 3; rr++) begin
         for (int cc = 0; cc < 4; cc++) begin
            on = 1'((rr + cc) % 2);
            send_pixel(on ? 8'hFF : 8'h00, on ? 8'h00 : 8'hFF, 8'(60 + 13 * rr + 7 * cc));
         end
      end
   endtask

   // undersized registers clamp to a 3x3 frame, upper data bits dropped
   task automatic test_min_clamp();
      apply_geometry(13'h1802, 13'd0, 1'b1);
      repeat (9) send_random_pixel();
      apply_geometry(13'd2, 13'd1, 1'b0);
      finish_frame();
   endtask

   // oversized registers clamp; a long first row is cut short by a width shrink
   task automatic test_max_width();
      apply_geometry(13'h07FF, 13'h1FFF, 1'b1);
      repeat (LongRowPart) send_random_pixel();
      apply_geometry(13'd3, 13'd3, 1'b1);
      finish_frame();
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      apply_geometry(13'd10, 13'd5, 1'b1);
      repeat (10) send_random_pixel();
      no_idle = 1'b1;
      stall_request = 1'b1;
      finish_frame();
      no_idle = 1'b0;
   endtask

   // back-to-back words on both sides
   task automatic test_steady_stream();
      no_idle = 1'b1;
      apply_geometry(13'd12, 13'd6, 1'b0);
      finish_frame();
      send_random_pixel();
      finish_frame();
      apply_geometry(13'd9, 13'd5, 1'b1);
      send_random_pixel();
      finish_frame();
      no_idle = 1'b0;
   endtask

   // random small frames, some cut short by a mid-frame shrink
   task automatic test_random_frames();
      int unsigned w, h, n, start;
      bit          color;
      start = pixels_sent;
      while (pixels_sent - start < RandomItems) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(3, 12);
         h = $urandom_range(3, 7);
         color = 1'($urandom_range(1));
         apply_geometry(CsrDataW'(w), CsrDataW'(h), color);
         if ($urandom_range(3) == 0 && h >= 4) begin
            n = $urandom_range(w + 1, w * h - 2);
            repeat (n) send_random_pixel();
            if ($urandom_range(1))
               apply_geometry(CsrDataW'($urandom_range(3, w)), CsrDataW'(h), color);
            else
               apply_geometry(CsrDataW'(w), CsrDataW'($urandom_range(3, h)), color);
         end
         send_random_pixel();
         finish_frame();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.chan_a = '0;
      req_ch.chan_b = '0;
      req_ch.chan_c = '0;
      rsp_ch.ready  = 1'b0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = CSR_FRAME_WIDTH;
      csr_ch.data   = '0;
      for (int i = 0; i < LineDepth; i++) begin
         far_line[i]  = '0;
         near_line[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_start_and_regrid();
      test_saturation();
      test_min_clamp();
      test_max_width();
      test_backpressure();
      test_steady_stream();
      test_random_frames();

      quiesce();
      $display("streamed %0d pixel words through %0d register settings, %0d result words checked",
               pixels_sent, settings_applied, words_checked);
      $display("grey and colour, clip limits, border rows, clamped and mid-frame geometry");
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(WatchdogNs);
      $display("timeout with %0d result words still due", sharpened_due.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
